@@ rtl/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int MAX_ORDERS   = 32;
  localparam int DEPTH_LEVELS = 5;
  localparam int PRICE_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_ORDERS);
  localparam int LVL_W        = $clog2(DEPTH_LEVELS + 1);
  localparam int QTY_W        = 24;
  localparam int TOT_W        = 30;
  localparam int ID_W         = 32;
  localparam int AGE_W        = 32;
  localparam int KIND_W       = 4;

  // commands
  localparam logic [1:0] CMD_NEW    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_SNAP   = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] K_TRADE     = 4'd0;
  localparam logic [KIND_W-1:0] K_RESTED    = 4'd1;
  localparam logic [KIND_W-1:0] K_DONE      = 4'd2;
  localparam logic [KIND_W-1:0] K_FULL      = 4'd3;
  localparam logic [KIND_W-1:0] K_ZERO      = 4'd4;
  localparam logic [KIND_W-1:0] K_CANCEL    = 4'd5;
  localparam logic [KIND_W-1:0] K_MISS      = 4'd6;
  localparam logic [KIND_W-1:0] K_ASK       = 4'd7;
  localparam logic [KIND_W-1:0] K_BID       = 4'd8;
  localparam logic [KIND_W-1:0] K_ASK_EMPTY = 4'd9;
  localparam logic [KIND_W-1:0] K_BID_EMPTY = 4'd10;

  // compare unit modes
  localparam logic [1:0] M_BEST   = 2'd0;
  localparam logic [1:0] M_CANCEL = 2'd1;
  localparam logic [1:0] M_LEVEL  = 2'd2;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // one store entry as seen by the compare unit
  typedef struct packed {
    logic                  valid;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [ID_W-1:0]       ident;
    logic [AGE_W-1:0]      age;
  } ent_t;

  // running candidate of a scan
  typedef struct packed {
    logic                  have;
    logic [PRICE_BITS-1:0] price;
    logic [AGE_W-1:0]      age;
  } cand_t;

  // compare unit verdict
  typedef struct packed {
    logic take;
    logic merge;
  } cmp_t;

  // one result beat
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [ID_W-1:0]       buyer;
    logic [ID_W-1:0]       seller;
    logic [PRICE_BITS-1:0] price;
    logic [TOT_W-1:0]      qty;
  } res_t;

endpackage

@@ rtl/lobm_cmp.sv @@
// ----------------------------------------------------------------------------
// lobm_cmp
// Shared compare unit: judges one store entry against the scan candidate.
// ----------------------------------------------------------------------------
module lobm_cmp import lobm_pkg::*; (
  input  logic [1:0]            mode,
  input  ent_t                  ent,
  input  logic                  want_side,
  input  logic [ID_W-1:0]       want_id,
  input  cand_t                 cand,
  input  logic                  have_prev,
  input  logic [PRICE_BITS-1:0] prev_price,
  output cmp_t                  verdict
);

  logic hit;
  logic better;
  logic eq;
  logic beyond;

  always_comb begin
    hit     = ent.valid && ((mode == M_CANCEL) ? (ent.ident == want_id)
                                               : (ent.side == want_side));
    // asks: lower is better, bids: higher is better
    better  = want_side ? (ent.price < cand.price) : (ent.price > cand.price);
    eq      = ent.price == cand.price;
    beyond  = !have_prev || (want_side ? (ent.price > prev_price)
                                       : (ent.price < prev_price));
    verdict = '0;
    unique case (mode)
      M_BEST: begin
        verdict.take = hit && (!cand.have || better || (eq && ent.age > cand.age));
      end
      M_CANCEL: begin
        verdict.take = hit && (!cand.have || ent.age > cand.age);
      end
      M_LEVEL: begin
        verdict.take  = hit && beyond && (!cand.have || better);
        verdict.merge = hit && beyond && cand.have && eq;
      end
      default: verdict = '0;
    endcase
  end

endmodule

@@ rtl/limit_order_book_matcher.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book over a 32-entry store, one entry per cycle.
// Each search walks the whole store, then decides in a closing state.
// New orders, cancels and snapshots are taken one item at a time.
// Results leave through a one-beat hold stage and an output register.
// Reset (rst_n low, synchronous) empties the store and the arrival counter.
// ----------------------------------------------------------------------------
module limit_order_book_matcher import lobm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // order_id[31:0], side[32], limit_price[48:33],
                                   // quantity[72:49], zero fill
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // buyer_id[31:0], seller_id[63:32],
                                   // price_out[79:64], quantity_out[109:80], zero fill
  output logic [3:0]   out_tuser,  // kind
  output logic         out_tlast
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BEST   = 4'd1;
  localparam logic [3:0] S_MATCH  = 4'd2;
  localparam logic [3:0] S_REST   = 4'd3;
  localparam logic [3:0] S_CANCEL = 4'd4;
  localparam logic [3:0] S_CDONE  = 4'd5;
  localparam logic [3:0] S_LEVEL  = 4'd6;
  localparam logic [3:0] S_LDONE  = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDERS - 1);

  // store
  logic [MAX_ORDERS-1:0] valid_r, valid_nxt;
  logic                  ent_side_r  [MAX_ORDERS];
  logic [PRICE_BITS-1:0] ent_price_r [MAX_ORDERS];
  logic [QTY_W-1:0]      ent_qty_r   [MAX_ORDERS];
  logic [ID_W-1:0]       ent_id_r    [MAX_ORDERS];
  logic [AGE_W-1:0]      ent_arr_r   [MAX_ORDERS];
  logic [AGE_W-1:0]      ctr_r, ctr_nxt;

  // sequencer and item
  logic [3:0]            state_r, state_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic                  side_r, side_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [QTY_W-1:0]      rem_r, rem_nxt;
  logic                  zero_r, zero_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;

  // scan candidate
  cand_t                 cand_r, cand_nxt;
  logic [IDX_W-1:0]      cidx_r, cidx_nxt;
  logic [TOT_W-1:0]      tot_r, tot_nxt;

  // snapshot walk
  logic                  ssd_r, ssd_nxt;
  logic                  hprev_r, hprev_nxt;
  logic [PRICE_BITS-1:0] prev_r, prev_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;

  // hold stage and output register
  res_t                  hold_r, hold_nxt;
  logic                  hold_v_r, hold_v_nxt;
  res_t                  out_r, out_nxt;
  logic                  out_v_r, out_v_nxt;
  logic                  out_last_r, out_last_nxt;

  // store write controls
  logic                  ent_we;
  logic                  qty_we;
  logic [IDX_W-1:0]      wr_idx;
  logic [QTY_W-1:0]      wr_qty;

  logic [1:0]            mode;
  logic                  want_side;
  ent_t                  cur;
  cmp_t                  verdict;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_have;
  logic [QTY_W-1:0]      fill;
  logic                  emit;
  res_t                  emit_res;
  logic                  out_free;
  logic                  emit_ok;
  logic                  in_beat;

  assign in_beat   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_v_r || out_tready;
  assign emit_ok   = !hold_v_r || out_free;

  // entry under the scan pointer
  always_comb begin
    cur.valid = valid_r[idx_r];
    cur.side  = ent_side_r[idx_r];
    cur.price = ent_price_r[idx_r];
    cur.ident = ent_id_r[idx_r];
    cur.age   = ctr_r - ent_arr_r[idx_r];
  end

  always_comb begin
    unique case (state_r)
      S_CANCEL: mode = M_CANCEL;
      S_LEVEL:  mode = M_LEVEL;
      default:  mode = M_BEST;
    endcase
  end

  assign want_side = (state_r == S_LEVEL) ? ssd_r : ~side_r;

  lobm_cmp u_cmp (
    .mode       (mode),
    .ent        (cur),
    .want_side  (want_side),
    .want_id    (id_r),
    .cand       (cand_r),
    .have_prev  (hprev_r),
    .prev_price (prev_r),
    .verdict    (verdict)
  );

  // first free entry
  always_comb begin
    free_idx  = '0;
    free_have = 1'b0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx  = IDX_W'(i);
        free_have = 1'b1;
      end
    end
  end

  assign fill = (rem_r < ent_qty_r[cidx_r]) ? rem_r : ent_qty_r[cidx_r];

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    id_nxt     = id_r;
    side_nxt   = side_r;
    price_nxt  = price_r;
    rem_nxt    = rem_r;
    zero_nxt   = zero_r;
    idx_nxt    = idx_r;
    cand_nxt   = cand_r;
    cidx_nxt   = cidx_r;
    tot_nxt    = tot_r;
    ssd_nxt    = ssd_r;
    hprev_nxt  = hprev_r;
    prev_nxt   = prev_r;
    lvl_nxt    = lvl_r;
    ctr_nxt    = ctr_r;
    valid_nxt  = valid_r;
    ent_we     = 1'b0;
    qty_we     = 1'b0;
    wr_idx     = cidx_r;
    wr_qty     = '0;
    emit       = 1'b0;
    emit_res   = '0;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_last_nxt = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          id_nxt    = in_tdata[31:0];
          side_nxt  = in_tdata[32];
          price_nxt = in_tdata[48:33];
          rem_nxt   = in_tdata[72:49];
          zero_nxt  = (in_tdata[72:49] == '0);
          idx_nxt   = '0;
          cand_nxt  = '0;
          tot_nxt   = '0;
          ssd_nxt   = SIDE_SELL;
          hprev_nxt = 1'b0;
          lvl_nxt   = '0;
          case (in_tuser)
            CMD_NEW:    state_nxt = (in_tdata[72:49] == '0) ? S_REST : S_BEST;
            CMD_CANCEL: state_nxt = S_CANCEL;
            CMD_SNAP:   state_nxt = S_LEVEL;
            default:    state_nxt = S_FLUSH;
          endcase
        end
      end

      // walk the store for the best opposite entry, or the entry to cancel
      S_BEST, S_CANCEL: begin
        if (verdict.take) begin
          cand_nxt.have  = 1'b1;
          cand_nxt.price = cur.price;
          cand_nxt.age   = cur.age;
          cidx_nxt       = idx_r;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = (state_r == S_BEST) ? S_MATCH : S_CDONE;
        end
      end

      S_MATCH: begin
        if (!cand_r.have || ent_id_r[cidx_r] == id_r ||
            (price_r != '0 && (side_r == SIDE_BUY ? cand_r.price > price_r
                                                  : cand_r.price < price_r))) begin
          state_nxt = S_REST;
        end else if (emit_ok) begin
          emit           = 1'b1;
          emit_res.kind  = K_TRADE;
          emit_res.buyer = (side_r == SIDE_BUY) ? id_r : ent_id_r[cidx_r];
          emit_res.seller = (side_r == SIDE_BUY) ? ent_id_r[cidx_r] : id_r;
          emit_res.price = cand_r.price;
          emit_res.qty   = TOT_W'(fill);
          qty_we         = 1'b1;
          wr_qty         = ent_qty_r[cidx_r] - fill;
          if (ent_qty_r[cidx_r] == fill) begin
            valid_nxt[cidx_r] = 1'b0;
          end
          rem_nxt  = rem_r - fill;
          idx_nxt  = '0;
          cand_nxt = '0;
          state_nxt = (rem_r == fill) ? S_REST : S_BEST;
        end
      end

      // closing status of a new order
      S_REST: begin
        if (emit_ok) begin
          emit           = 1'b1;
          emit_res.buyer = id_r;
          emit_res.price = price_r;
          emit_res.qty   = TOT_W'(rem_r);
          if (zero_r) begin
            emit_res.kind = K_ZERO;
            emit_res.qty  = '0;
          end else if (rem_r == '0 || price_r == '0) begin
            emit_res.kind = K_DONE;
          end else if (!free_have) begin
            emit_res.kind = K_FULL;
          end else begin
            emit_res.kind       = K_RESTED;
            ent_we              = 1'b1;
            wr_idx              = free_idx;
            valid_nxt[free_idx] = 1'b1;
            ctr_nxt             = ctr_r + 1'b1;
          end
          state_nxt = S_FLUSH;
        end
      end

      S_CDONE: begin
        if (emit_ok) begin
          emit           = 1'b1;
          emit_res.buyer = id_r;
          if (cand_r.have) begin
            emit_res.kind     = K_CANCEL;
            emit_res.price    = ent_price_r[cidx_r];
            emit_res.qty      = TOT_W'(ent_qty_r[cidx_r]);
            valid_nxt[cidx_r] = 1'b0;
          end else begin
            emit_res.kind = K_MISS;
          end
          state_nxt = S_FLUSH;
        end
      end

      // next price level beyond the previous one, summing its quantity
      S_LEVEL: begin
        if (verdict.take) begin
          cand_nxt.have  = 1'b1;
          cand_nxt.price = cur.price;
          tot_nxt        = TOT_W'(ent_qty_r[idx_r]);
        end else if (verdict.merge) begin
          tot_nxt = tot_r + TOT_W'(ent_qty_r[idx_r]);
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_LDONE;
        end
      end

      S_LDONE: begin
        if (emit_ok) begin
          idx_nxt  = '0;
          cand_nxt = '0;
          tot_nxt  = '0;
          if (cand_r.have) begin
            emit           = 1'b1;
            emit_res.kind  = ssd_r ? K_ASK : K_BID;
            emit_res.price = cand_r.price;
            emit_res.qty   = tot_r;
            prev_nxt       = cand_r.price;
            hprev_nxt      = 1'b1;
            lvl_nxt        = lvl_r + 1'b1;
          end else if (!hprev_r) begin
            emit          = 1'b1;
            emit_res.kind = ssd_r ? K_ASK_EMPTY : K_BID_EMPTY;
          end
          if (cand_r.have && lvl_r != LVL_W'(DEPTH_LEVELS - 1)) begin
            state_nxt = S_LEVEL;
          end else if (ssd_r == SIDE_SELL) begin
            ssd_nxt   = SIDE_BUY;
            hprev_nxt = 1'b0;
            lvl_nxt   = '0;
            state_nxt = S_LEVEL;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      // final beat leaves with the last flag
      S_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt      = hold_r;
          out_v_nxt    = 1'b1;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // new beat pushes the held one out, not last
    if (emit) begin
      if (hold_v_r) begin
        out_nxt      = hold_r;
        out_v_nxt    = 1'b1;
        out_last_nxt = 1'b0;
      end
      hold_nxt   = emit_res;
      hold_v_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      ctr_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      ctr_r    <= ctr_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    side_r     <= side_nxt;
    price_r    <= price_nxt;
    rem_r      <= rem_nxt;
    zero_r     <= zero_nxt;
    idx_r      <= idx_nxt;
    cand_r     <= cand_nxt;
    cidx_r     <= cidx_nxt;
    tot_r      <= tot_nxt;
    ssd_r      <= ssd_nxt;
    hprev_r    <= hprev_nxt;
    prev_r     <= prev_nxt;
    lvl_r      <= lvl_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // store writes
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_side_r[wr_idx]  <= side_r;
      ent_price_r[wr_idx] <= price_r;
      ent_qty_r[wr_idx]   <= rem_r;
      ent_id_r[wr_idx]    <= id_r;
      ent_arr_r[wr_idx]   <= ctr_r;
    end else if (qty_we) begin
      ent_qty_r[wr_idx]   <= wr_qty;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_r.qty, out_r.price, out_r.seller, out_r.buyer};

endmodule

@@ rtl/lobm_checker.sv @@
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks of the order book matcher, bound to the top level.
// ----------------------------------------------------------------------------
module lobm_checker import lobm_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [3:0]   out_tuser,
  input logic         out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // a trade is never the closing result
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_TRADE |-> !out_tlast)
    else $error("trade flagged last");

  // kinds stay in range
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= K_BID_EMPTY)
    else $error("unknown result kind");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
